// ----- src/xor_checked_frame_receiver_assert.svh -----
// Assertion macros for the frame receiver checker.
`ifndef XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Checked outside reset only.
`define XCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define XCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/xcfr_pkg.sv -----
`timescale 1ns / 1ps

package xcfr_pkg;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned AddrW    = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam int unsigned IdxW     = $clog2(BufDepth + 1);
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ByteW-1:0] BufDepthB      = ByteW'(BufDepth);
  localparam logic [ByteW-1:0] StartMarkerRst = 8'hAA;
  localparam logic [ByteW-1:0] AcceptedKindRst = 8'h02;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadSum  = 2'd1,
    StBadKind = 2'd2,
    StTooLong = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartMarker  = 1'b0,
    CfgAcceptedKind = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// ----- src/xcfr_rx_if.sv -----
`timescale 1ns / 1ps

interface xcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/xcfr_res_if.sv -----
`timescale 1ns / 1ps

interface xcfr_res_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           payload_byte;
  logic                 byte_present;
  logic                 last_of_frame;
  xcfr_pkg::status_e    frame_status;

  modport source (
    output valid, output payload_byte, output byte_present,
    output last_of_frame, output frame_status, input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_present,
    input last_of_frame, input frame_status, output ready
  );
endinterface

// ----- src/xcfr_store.sv -----
`timescale 1ns / 1ps

module xcfr_store (
  input  logic                          clk_i,
  input  xcfr_pkg::mem_req_t            mem_req_i,
  output logic [xcfr_pkg::ByteW-1:0]    rdata_o
);
  import xcfr_pkg::*;

  logic [ByteW-1:0] mem_q [BufDepth];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/xcfr_ctrl.sv -----
`timescale 1ns / 1ps

module xcfr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xcfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [xcfr_pkg::CfgDataW-1:0] cfg_data_i,
  xcfr_rx_if.sink                       rx,
  xcfr_res_if.source                    res,
  output xcfr_pkg::mem_req_t            mem_req_o,
  input  logic [xcfr_pkg::ByteW-1:0]    mem_rdata_i
);
  import xcfr_pkg::*;

  typedef enum logic [5:0] {
    PhHunt    = 6'b000001,
    PhLength  = 6'b000010,
    PhKind    = 6'b000100,
    PhPayload = 6'b001000,
    PhCheck   = 6'b010000,
    PhEmit    = 6'b100000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] start_marker_q, accepted_kind_q;
  logic [ByteW-1:0] frame_length_q, frame_length_d;
  logic [ByteW-1:0] frame_kind_q, frame_kind_d;
  logic [ByteW-1:0] bytes_seen_q, bytes_seen_d;
  logic [ByteW-1:0] running_xor_q, running_xor_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d, rd_idx_inc;
  logic             rd_pend_q, rd_last_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_present_q, out_last_q;
  status_e          out_status_q;

  logic    out_free, load_rd, issue_rd, rd_last;
  logic    rx_ready, in_acc, emit_burst, verdict_now;
  status_e verdict;

  assign out_free = !out_valid_q || res.ready;
  assign load_rd  = rd_pend_q && out_free;

  always_comb begin
    unique case (phase_q)
      PhEmit:  rx_ready = 1'b0;
      PhCheck: rx_ready = !rd_pend_q && out_free;
      default: rx_ready = 1'b1;
    endcase
  end

  assign in_acc = rx.valid && rx_ready;

  always_comb begin
    priority if (frame_length_q > BufDepthB) begin
      verdict = StTooLong;
    end else if (rx.rx_byte != running_xor_q) begin
      verdict = StBadSum;
    end else if (frame_kind_q != accepted_kind_q) begin
      verdict = StBadKind;
    end else begin
      verdict = StOk;
    end
  end

  assign emit_burst  = (verdict == StOk) && (frame_length_q != '0);
  assign verdict_now = in_acc && (phase_q == PhCheck);

  assign issue_rd   = (phase_q == PhEmit) && (!rd_pend_q || load_rd);
  assign rd_idx_inc = rd_idx_q + IdxW'(1);
  assign rd_last    = (ByteW'(rd_idx_inc) == frame_length_q);

  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    frame_kind_d   = frame_kind_q;
    bytes_seen_d   = bytes_seen_q;
    running_xor_d  = running_xor_q;
    rd_idx_d       = rd_idx_q;
    unique case (phase_q)
      PhLength: begin
        if (in_acc) begin
          frame_length_d = rx.rx_byte;
          phase_d        = PhKind;
        end
      end
      PhKind: begin
        if (in_acc) begin
          frame_kind_d  = rx.rx_byte;
          bytes_seen_d  = '0;
          running_xor_d = '0;
          phase_d       = (frame_length_q == '0) ? PhCheck : PhPayload;
        end
      end
      PhPayload: begin
        if (in_acc) begin
          running_xor_d = running_xor_q ^ rx.rx_byte;
          bytes_seen_d  = bytes_seen_q + ByteW'(1);
          if (bytes_seen_d >= frame_length_q) begin
            phase_d = PhCheck;
          end
        end
      end
      PhCheck: begin
        if (in_acc) begin
          rd_idx_d = '0;
          phase_d  = emit_burst ? PhEmit : PhHunt;
        end
      end
      PhEmit: begin
        if (issue_rd) begin
          rd_idx_d = rd_idx_inc;
          if (rd_last) begin
            phase_d = PhHunt;
          end
        end
      end
      default: begin
        if (in_acc) begin
          phase_d = (rx.rx_byte == start_marker_q) ? PhLength : PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHunt;
      frame_length_q <= '0;
      frame_kind_q   <= '0;
      bytes_seen_q   <= '0;
      running_xor_q  <= '0;
      rd_idx_q       <= '0;
    end else begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      frame_kind_q   <= frame_kind_d;
      bytes_seen_q   <= bytes_seen_d;
      running_xor_q  <= running_xor_d;
      rd_idx_q       <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= StartMarkerRst;
      accepted_kind_q <= AcceptedKindRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgStartMarker:  start_marker_q  <= cfg_data_i[ByteW-1:0];
        CfgAcceptedKind: accepted_kind_q <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // read pending: data sits in the store's output register until loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
    end else if (issue_rd) begin
      rd_pend_q <= 1'b1;
      rd_last_q <= rd_last;
    end else if (load_rd) begin
      rd_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_rd || (verdict_now && !emit_burst)) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rd) begin
      out_byte_q    <= mem_rdata_i;
      out_present_q <= 1'b1;
      out_last_q    <= rd_last_q;
      out_status_q  <= StOk;
    end else if (verdict_now && !emit_burst) begin
      out_byte_q    <= '0;
      out_present_q <= 1'b0;
      out_last_q    <= 1'b1;
      out_status_q  <= verdict;
    end
  end

  assign rx.ready          = rx_ready;
  assign res.valid         = out_valid_q;
  assign res.payload_byte  = out_byte_q;
  assign res.byte_present  = out_present_q;
  assign res.last_of_frame = out_last_q;
  assign res.frame_status  = out_status_q;

  assign mem_req_o.we    = in_acc && (phase_q == PhPayload) && (bytes_seen_q < BufDepthB);
  assign mem_req_o.waddr = bytes_seen_q[AddrW-1:0];
  assign mem_req_o.wdata = rx.rx_byte;
  assign mem_req_o.re    = issue_rd;
  assign mem_req_o.raddr = rd_idx_q[AddrW-1:0];

endmodule

// ----- src/xor_checked_frame_receiver.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// rx_i      in   valid / ready             rx_byte
// res_o     out  valid / ready             payload_byte, byte_present,
//                                          last_of_frame, frame_status
// cfg       in   cfg_we_i (no handshake)   cfg_idx_i, cfg_data_i
//
// One received byte per cycle outside a payload burst.
// After the checksum of a good N-byte frame the store is read once a cycle unless the
// output stalls, and no byte is taken until all N reads are issued.
// A status-only verdict is valid the cycle after its checksum byte.
// A checksum byte waits while the output register or a store read is busy.
// Reset is asynchronous; no clearing pass, the store is read only where written.

module xor_checked_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xcfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [xcfr_pkg::CfgDataW-1:0] cfg_data_i,
  xcfr_rx_if.sink                       rx_i,
  xcfr_res_if.source                    res_o
);
  import xcfr_pkg::*;

  mem_req_t         mem_req;
  logic [ByteW-1:0] mem_rdata;

  xcfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx          (rx_i),
    .res         (res_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  xcfr_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

endmodule

// ----- src/xcfr_checker.sv -----
`timescale 1ns / 1ps
`include "xor_checked_frame_receiver_assert.svh"

module xcfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_i,
  input logic       byte_present_i,
  input logic       last_of_frame_i,
  input logic [1:0] frame_status_i
);
  import xcfr_pkg::*;

  `XCFR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i) && $stable(byte_present_i) && $stable(last_of_frame_i) && $stable(frame_status_i), "result changed while stalled")

  `XCFR_ASSERT_ALWAYS(a_status_only, out_valid_i && !byte_present_i |-> last_of_frame_i && (payload_byte_i == 8'd0), "status result not final or not zero")

  `XCFR_ASSERT(a_byte_ok, out_valid_i && byte_present_i |-> frame_status_i == StOk, "payload byte with bad status")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .payload_byte_i  (res_o.payload_byte),
  .byte_present_i  (res_o.byte_present),
  .last_of_frame_i (res_o.last_of_frame),
  .frame_status_i  (res_o.frame_status)
);

// ----- tb/xor_checked_frame_receiver_tb.sv -----
`timescale 1ns / 1ps

module xor_checked_frame_receiver_tb;
  import xcfr_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int TailCycles = 8;

  typedef enum logic [2:0] {
    PhHunt,
    PhLength,
    PhKind,
    PhPayload,
    PhCheck
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       last_of_frame;
    status_e    frame_status;
  } verdict_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  xcfr_rx_if  rx_if();
  xcfr_res_if res_if();

  xor_checked_frame_receiver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  // Receiver model state
  logic [7:0] marker_q     = StartMarkerRst;
  logic [7:0] kind_sel_q   = AcceptedKindRst;
  rx_phase_e  rx_phase     = PhHunt;
  logic [7:0] frame_len_q  = 8'h00;
  logic [7:0] frame_kind_q = 8'h00;
  logic [7:0] seen_q       = 8'h00;
  logic [7:0] xor_q        = 8'h00;
  logic [7:0] frame_store [BufDepth];

  verdict_t   verdicts_due[$];
  verdict_t   want;
  int         mismatches        = 0;
  int         bytes_sent        = 0;
  int         verdicts_forecast = 0;
  int         ready_hold        = 0;
  int         cycles            = 0;
  bit         quiet             = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] n;
    do n = 8'($urandom_range(0, 255)); while (n == marker_q);
    return n;
  endfunction

  function automatic logic [7:0] payload_pick();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return marker_q;
    if (r == 1) return 8'h00;
    if (r == 2) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Advance the receiver model by one byte and queue any results it causes
  task automatic absorb_rx_byte(input logic [7:0] b);
    status_e  st;
    verdict_t v;
    case (rx_phase)
      PhLength: begin
        frame_len_q = b;
        rx_phase    = PhKind;
      end
      PhKind: begin
        frame_kind_q = b;
        seen_q       = 8'h00;
        xor_q        = 8'h00;
        rx_phase     = (frame_len_q == 8'h00) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        if (seen_q < BufDepth) frame_store[seen_q[AddrW-1:0]] = b;
        xor_q  = xor_q ^ b;
        seen_q = seen_q + 8'd1;
        if (seen_q >= frame_len_q) rx_phase = PhCheck;
      end
      PhCheck: begin
        if (frame_len_q > BufDepth) st = StTooLong;
        else if (b != xor_q) st = StBadSum;
        else if (frame_kind_q != kind_sel_q) st = StBadKind;
        else st = StOk;
        if (st != StOk || frame_len_q == 8'h00) begin
          v = '{payload_byte: 8'h00, byte_present: 1'b0, last_of_frame: 1'b1,
                frame_status: st};
          verdicts_due.push_back(v);
          verdicts_forecast++;
        end else begin
          for (int k = 0; k < frame_len_q; k++) begin
            v = '{payload_byte: frame_store[k], byte_present: 1'b1,
                  last_of_frame: (k + 1 == frame_len_q), frame_status: StOk};
            verdicts_due.push_back(v);
            verdicts_forecast++;
          end
        end
        rx_phase = PhHunt;
      end
      default: rx_phase = (b == marker_q) ? PhLength : PhHunt;
    endcase
  endtask

  // One request per call; valid stays high so the next call can follow back to back
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    absorb_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    rx_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgStartMarker:  marker_q   = val;
      CfgAcceptedKind: kind_sel_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_frame(input int len, input logic [7:0] kind, input bit corrupt);
    logic [7:0] p;
    logic [7:0] sum;
    sum = 8'h00;
    send_byte(marker_q);
    send_byte(8'(len));
    send_byte(kind);
    for (int i = 0; i < len; i++) begin
      p = payload_pick();
      sum ^= p;
      send_byte(p);
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Close whatever frame is open, then let the block go quiet
  task automatic settle();
    while (rx_phase != PhHunt) send_byte(8'($urandom_range(0, 255)));
    wait_drain();
  endtask

  task automatic random_frame();
    int         r;
    int         len;
    logic [7:0] kind;
    bit         corrupt;
    quiet = ($urandom_range(0, 5) == 0);
    r = $urandom_range(0, 99);
    if (r < 20) repeat ($urandom_range(1, 4)) send_byte(noise_byte());
    else if (r < 25) repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 55) len = $urandom_range(0, 4);
    else if (r < 85) len = $urandom_range(5, 16);
    else if (r < 95) len = $urandom_range(17, 64);
    else if (r < 98) len = BufDepth;
    else len = $urandom_range(BufDepth + 1, BufDepth + 6);
    kind    = ($urandom_range(0, 9) < 7) ? kind_sel_q : 8'($urandom_range(0, 255));
    corrupt = ($urandom_range(0, 99) < 15);
    send_frame(len, kind, corrupt);
    if ($urandom_range(0, 9) == 0) wait_drain();
    quiet = 1'b0;
  endtask

  task automatic test_empty_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, kind_sel_q, 1'b0);
    send_frame(0, ~kind_sel_q, 1'b0);
    send_frame(0, kind_sel_q, 1'b1);
    wait_drain();
  endtask

  task automatic test_payload_and_priority();
    send_byte(marker_q);
    send_byte(8'd2);
    send_byte(kind_sel_q);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_frame(3, kind_sel_q ^ 8'h01, 1'b1);
    send_frame(2, kind_sel_q ^ 8'h80, 1'b0);
    // start byte reused as type and as both payload bytes
    send_byte(marker_q);
    send_byte(8'd2);
    send_byte(marker_q);
    send_byte(marker_q);
    send_byte(marker_q);
    send_byte(8'h00);
    wait_drain();
  endtask

  task automatic test_buffer_limits();
    send_frame(1, kind_sel_q, 1'b0);
    send_frame(BufDepth, kind_sel_q, 1'b0);
    send_frame(BufDepth + 1, kind_sel_q ^ 8'h04, 1'b1);
    wait_drain();
  endtask

  task automatic test_register_settings();
    logic [7:0] markers [4] = '{8'h00, 8'hFF, 8'h5A, StartMarkerRst};
    logic [7:0] kinds   [4] = '{8'h00, 8'hFF, 8'h5A, AcceptedKindRst};
    for (int s = 0; s < 4; s++) begin
      settle();
      write_reg(CfgStartMarker, markers[s]);
      write_reg(CfgAcceptedKind, kinds[s]);
      repeat (2) random_frame();
    end
    settle();
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int byte_goal;
    int verdict_goal;
    byte_goal    = bytes_sent + n_bytes;
    verdict_goal = verdicts_forecast + 12;
    while (bytes_sent < byte_goal || verdicts_forecast < verdict_goal) random_frame();
    settle();
  endtask

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      res_if.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      res_if.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 2) == 0) ready_hold <= idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result: payload_byte %0h byte_present %0b last_of_frame %0b",
               res_if.payload_byte, res_if.byte_present, res_if.last_of_frame);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (res_if.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                 res_if.payload_byte);
          mismatches++;
        end
        if (res_if.byte_present !== want.byte_present) begin
          $error("byte_present: expected %0b, got %0b", want.byte_present,
                 res_if.byte_present);
          mismatches++;
        end
        if (res_if.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                 res_if.last_of_frame);
          mismatches++;
        end
        if (res_if.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status,
                 res_if.frame_status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgStartMarker;
    cfg_data        = '0;
    rx_if.valid     = 1'b0;
    rx_if.rx_byte   = 8'h00;
    res_if.ready    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_frames();
    test_payload_and_priority();
    test_buffer_limits();
    test_register_settings();
    test_random_traffic(40);
    wait_drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
